// ----- rtl/pra_pkg.sv -----
// Package with the types, constants and helpers of the page region allocator.
package pra_pkg;

    localparam int MAX_REGIONS = 256;
    localparam int PAGE_BITS   = 12;

    localparam int ADDR_W  = 32;
    localparam int PAGES_W = 20;
    localparam int IDX_W   = $clog2(MAX_REGIONS);
    localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
    localparam int REQ_W   = ADDR_W + 1 - PAGE_BITS;
    localparam int CFG_IDX_W = 1;

    localparam logic [PAGES_W-1:0] PAGES_MAX  = {PAGES_W{1'b1}};
    localparam logic [ADDR_W-1:0]  PAGE_BYTES = ADDR_W'(1) << PAGE_BITS;

    // Actions
    localparam logic [1:0] ACT_ALLOC   = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_CHECK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL = 1'd1;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] request_bytes;
        logic [ADDR_W-1:0] address;
    } request_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  region_address;
        logic [PAGES_W-1:0] region_pages;
        logic [1:0]         status;
        logic               legitimate;
    } result_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [PAGES_W-1:0] pages;
    } entry_t;

    // Page count of the pool, saturated to the page counter width
    function automatic logic [PAGES_W-1:0] pool_pages(input logic [ADDR_W-1:0] bytes);
        logic [ADDR_W-1:0] shifted;
        shifted = bytes >> PAGE_BITS;
        if (shifted > ADDR_W'(PAGES_MAX))
            return PAGES_MAX;
        else
            return PAGES_W'(shifted);
    endfunction

endpackage

// ----- rtl/page_region_allocator.sv -----
// Page region allocator: bump allocator with a region table held in a memory.
//
// Usage:
//   request channel (request_valid/request_ready/request) carries one item with
//   an action (allocate, release, check), a byte count and an address. Each
//   item gives exactly one result item on the result channel
//   (result_valid/result_ready/result).
//   cfg channel writes base_address (index 0) or pool_bytes (index 1); a write
//   restarts the pool: the table empties and the free count is reloaded.
//   Configure only while no item is in flight.
// Sequence:
//   check, allocate into an empty table and allocate errors go from the
//   execute state straight to the done state; allocate after earlier regions
//   first reads the last table entry. Release, hit or miss, makes one read
//   per entry searched up to the match, then moves each later entry down one
//   place, each write overlapping the next read. The single table read port
//   sets this order. One item at a time; the next is accepted once this one
//   moves into the result register, even while that result waits.
// Reset: table empty, pool registers zero, so no pages are free.
// Stall: a held result keeps its value; a finished item waits until the
//   result register frees up.
module page_region_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         request_valid,
    output logic                         request_ready,
    input  pra_pkg::request_t            request,
    output logic                         result_valid,
    input  logic                         result_ready,
    output pra_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pra_pkg::ADDR_W-1:0]   cfg_data
);
    import pra_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_ALLOC_RD = 3'd2;
    localparam logic [2:0] S_SEARCH   = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         act_reg;
    logic [REQ_W-1:0]   req_pages_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PAGES_W-1:0] free_reg, free_next;
    logic [ADDR_W-1:0]  base_reg;
    logic [ADDR_W-1:0]  pool_reg;
    result_t            res_reg, res_next;
    result_t            out_reg;
    logic               out_valid_reg;

    // Region table memory
    entry_t             table_mem [MAX_REGIONS];
    logic               mem_wen;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic               mem_ren;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             mem_rdata;

    logic               accept;
    logic               cfg_write;
    logic               load_out;
    logic [ADDR_W:0]    req_round;
    logic [ADDR_W-1:0]  alloc_start;
    logic [PAGES_W+PAGE_BITS-1:0] span_full;
    logic [ADDR_W-1:0]  span;
    logic [PAGES_W:0]   free_sum;
    logic [ADDR_W:0]    pool_top;
    logic [IDX_W-1:0]   idx_p1;
    logic [IDX_W-1:0]   idx_p2;
    logic               idx_is_last;
    logic               next_is_last;
    logic [PAGES_W-1:0] alloc_pages;

    assign request_ready = (state_reg == S_IDLE);
    assign cfg_ready     = (state_reg == S_IDLE);
    assign accept        = request_valid && request_ready;
    assign cfg_write     = cfg_valid && cfg_ready;
    assign load_out      = (state_reg == S_DONE) && (!out_valid_reg || result_ready);

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Round the byte count up to pages (33-bit sum so the top page carries)
    assign req_round = {1'b0, request.request_bytes} + (ADDR_W + 1)'(PAGE_BYTES - 1);

    assign alloc_pages  = PAGES_W'(req_pages_reg);
    assign span_full    = {mem_rdata.pages, {PAGE_BITS{1'b0}}};
    assign span         = ADDR_W'(span_full);
    assign alloc_start  = mem_rdata.start + span;
    assign free_sum     = {1'b0, free_reg} + {1'b0, mem_rdata.pages};
    assign pool_top     = {1'b0, base_reg} + {1'b0, pool_reg};
    assign idx_p1       = idx_reg + IDX_W'(1);
    assign idx_p2       = idx_reg + IDX_W'(2);
    assign idx_is_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign next_is_last = (CNT_W'(idx_reg) + CNT_W'(2)) == count_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        free_next  = free_reg;
        res_next   = res_reg;
        mem_wen    = 1'b0;
        mem_waddr  = idx_reg;
        mem_wdata  = mem_rdata;
        mem_ren    = 1'b0;
        mem_raddr  = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_next = '0;
                state_next = S_DONE;
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        if ((ADDR_W + 1)'(req_pages_reg) > (ADDR_W + 1)'(free_reg))
                        begin
                            res_next.status = ST_NO_SPACE;
                        end
                        else if (count_reg >= CNT_W'(MAX_REGIONS))
                        begin
                            res_next.status = ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            // first region sits one page above the pool base
                            mem_wen         = 1'b1;
                            mem_waddr       = '0;
                            mem_wdata.start = base_reg + PAGE_BYTES;
                            mem_wdata.pages = alloc_pages;
                            count_next      = count_reg + CNT_W'(1);
                            free_next       = free_reg - alloc_pages;
                            res_next.region_address = base_reg + PAGE_BYTES;
                            res_next.region_pages   = alloc_pages;
                            res_next.status         = ST_OK;
                        end
                        else
                        begin
                            // fetch the last entry to find where it ends
                            mem_ren    = 1'b1;
                            mem_raddr  = IDX_W'(count_reg - CNT_W'(1));
                            state_next = S_ALLOC_RD;
                        end
                    end
                    ACT_RELEASE:
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            idx_next   = '0;
                            mem_ren    = 1'b1;
                            mem_raddr  = '0;
                            state_next = S_SEARCH;
                        end
                    end
                    ACT_CHECK:
                    begin
                        res_next.legitimate = (addr_reg >= base_reg) &&
                                              ({1'b0, addr_reg} < pool_top);
                    end
                    default:
                    begin
                        res_next = '0;
                    end
                endcase
            end
            S_ALLOC_RD:
            begin
                mem_wen         = 1'b1;
                mem_waddr       = IDX_W'(count_reg);
                mem_wdata.start = alloc_start;
                mem_wdata.pages = alloc_pages;
                count_next      = count_reg + CNT_W'(1);
                free_next       = free_reg - alloc_pages;
                res_next.region_address = alloc_start;
                res_next.region_pages   = alloc_pages;
                res_next.status         = ST_OK;
                state_next      = S_DONE;
            end
            S_SEARCH:
            begin
                if (mem_rdata.start == addr_reg)
                begin
                    res_next.region_address = mem_rdata.start;
                    res_next.region_pages   = mem_rdata.pages;
                    res_next.status         = ST_OK;
                    free_next = free_sum[PAGES_W] ? PAGES_MAX : free_sum[PAGES_W-1:0];
                    if (idx_is_last)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // start moving the later entries down one place
                        mem_ren    = 1'b1;
                        mem_raddr  = idx_p1;
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_is_last)
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next  = idx_p1;
                    mem_ren   = 1'b1;
                    mem_raddr = idx_p1;
                end
            end
            S_SHIFT:
            begin
                // read data is entry idx+1; write it back one place lower
                mem_wen   = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                idx_next  = idx_p1;
                if (next_is_last)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_ren   = 1'b1;
                    mem_raddr = idx_p2;
                end
            end
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a register write restarts the pool with the new settings
        if (cfg_write)
        begin
            count_next = '0;
            if (cfg_index == CFG_BASE)
                free_next = pool_pages(pool_reg);
            else
                free_next = pool_pages(cfg_data);
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            free_reg      <= '0;
            base_reg      <= '0;
            pool_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            if (cfg_write)
            begin
                if (cfg_index == CFG_BASE)
                    base_reg <= cfg_data;
                else
                    pool_reg <= cfg_data;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: hold the accepted item and the finished result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg       <= request.action;
            req_pages_reg <= req_round[ADDR_W:PAGE_BITS];
            addr_reg      <= request.address;
        end
        res_reg <= res_next;
        if (load_out)
            out_reg <= res_reg;
    end

    // Region table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_wen)
            table_mem[mem_waddr] <= mem_wdata;
        if (mem_ren)
            mem_rdata <= table_mem[mem_raddr];
    end

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for the page region allocator: driver, monitor and region predictor.
module tb_top;
    import pra_pkg::*;

    // Action code that the block must ignore with an all-zero result
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int LONG_HOLD   = 400;
    localparam int FILL_ALLOCS = MAX_REGIONS + 2;

    typedef struct {
        request_t req;
        bit       drain_first;
    } pending_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 request_valid = 1'b0;
    logic                 request_ready;
    request_t             request = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BASE;
    logic [ADDR_W-1:0]    cfg_data = '0;

    // Items waiting to be offered, and the outcomes still owed by the block
    pending_t request_q [$];
    result_t  outcome_q [$];

    // Predictor copy of the pool: registers, region table and counters
    logic [ADDR_W-1:0]  m_start [MAX_REGIONS];
    logic [PAGES_W-1:0] m_pages [MAX_REGIONS];
    int                 live_regions = 0;
    logic [PAGES_W-1:0] free_cnt = '0;
    logic [ADDR_W-1:0]  pool_base = '0;
    logic [ADDR_W-1:0]  pool_size = '0;

    int      fail_count = 0;
    int      cycles = 0;
    bit      calm = 1'b0;
    int      send_wait = 0;
    int      recv_wait = 0;
    int      hold_left = 0;
    int      hold_asks = 0;
    int      hold_seen = 0;
    result_t want;

    page_region_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_ready (request_ready),
        .request       (request),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Idle cycles before an item or after a result; none in calm phases
    function automatic int pick_gap();
        if (calm || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    // Work out the outcome of one accepted item and advance the pool copy
    function automatic result_t region_outcome(input request_t rq);
        result_t            r;
        logic [32:0]        padded;
        logic [20:0]        need;
        logic [20:0]        sum;
        logic [32:0]        top;
        logic [ADDR_W-1:0]  start;
        int                 hit;
        r = '0;
        case (rq.action)
            ACT_ALLOC:
            begin
                padded = {1'b0, rq.request_bytes} + {1'b0, PAGE_BYTES} - 33'd1;
                need   = padded[32:PAGE_BITS];
                if (need > {1'b0, free_cnt})
                    r.status = ST_NO_SPACE;
                else if (live_regions >= MAX_REGIONS)
                    r.status = ST_FULL;
                else
                begin
                    // Bump past the last region, or one page above the base
                    if (live_regions == 0)
                        start = pool_base + PAGE_BYTES;
                    else
                        start = m_start[live_regions-1] +
                                (ADDR_W'(m_pages[live_regions-1]) << PAGE_BITS);
                    m_start[live_regions] = start;
                    m_pages[live_regions] = need[PAGES_W-1:0];
                    live_regions++;
                    free_cnt = free_cnt - need[PAGES_W-1:0];
                    r.region_address = start;
                    r.region_pages   = need[PAGES_W-1:0];
                    r.status         = ST_OK;
                end
            end
            ACT_RELEASE:
            begin
                hit = -1;
                for (int i = 0; i < live_regions; i++)
                    if (hit < 0 && m_start[i] == rq.address)
                        hit = i;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.region_address = m_start[hit];
                    r.region_pages   = m_pages[hit];
                    r.status         = ST_OK;
                    sum = {1'b0, free_cnt} + {1'b0, m_pages[hit]};
                    // Close the gap: move later entries down one place
                    for (int i = hit; i + 1 < live_regions; i++)
                    begin
                        m_start[i] = m_start[i+1];
                        m_pages[i] = m_pages[i+1];
                    end
                    live_regions--;
                    free_cnt = sum[20] ? PAGES_MAX : sum[PAGES_W-1:0];
                end
            end
            ACT_CHECK:
            begin
                top = {1'b0, pool_base} + {1'b0, pool_size};
                r.legitimate = (rq.address >= pool_base) && ({1'b0, rq.address} < top);
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic request_t make_req(input logic [1:0] act, input logic [ADDR_W-1:0] bytes,
                                          input logic [ADDR_W-1:0] addr);
        request_t rq;
        rq.action        = act;
        rq.request_bytes = bytes;
        rq.address       = addr;
        return rq;
    endfunction

    // Mostly well-formed traffic: releases aim at likely region starts
    function automatic request_t random_item(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] size, input int span);
        request_t rq;
        int       pick;
        rq   = make_req(ACT_UNUSED, $urandom(), $urandom());
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            rq.action = ACT_ALLOC;
            case ($urandom_range(0, 9))
                0: ;
                1: rq.request_bytes = '0;
                2: rq.request_bytes = PAGE_BYTES * $urandom_range(1, 4);
                default: rq.request_bytes = $urandom_range(0, 3 * PAGE_BYTES);
            endcase
        end
        else if (pick < 80)
        begin
            rq.action = ACT_RELEASE;
            if ($urandom_range(0, 6) != 0)
                rq.address = base + PAGE_BYTES * $urandom_range(1, span);
        end
        else if (pick < 95)
        begin
            rq.action = ACT_CHECK;
            case ($urandom_range(0, 3))
                0: rq.address = base - 32'd1 + 32'($urandom_range(0, 2));
                1: rq.address = base + size - 32'd2 + 32'($urandom_range(0, 3));
                default: ;
            endcase
        end
        return rq;
    endfunction

    task automatic offer(input request_t rq, input bit drain);
        pending_t pe;
        pe.req         = rq;
        pe.drain_first = drain;
        request_q.push_back(pe);
    endtask

    // Hold until every item is accepted and answered, then let the block settle
    task automatic wait_idle();
        while (request_q.size() != 0 || request_valid || outcome_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write one register at a clock edge; the pool copy restarts as the block does
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_BASE)
            pool_base = val;
        else
            pool_size = val;
        live_regions = 0;
        free_cnt = ((pool_size >> PAGE_BITS) > ADDR_W'(PAGES_MAX)) ?
                   PAGES_MAX : PAGES_W'(pool_size >> PAGE_BITS);
        @(posedge clk);
    endtask

    // Driver: predict each accepted item, then offer the next after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_valid <= 1'b0;
            request       <= '0;
            send_wait     <= 0;
        end
        else
        begin
            if (request_valid && request_ready)
                outcome_q.push_back(region_outcome(request));
            // Hold the payload while an offered item is not yet taken
            if (!request_valid || request_ready)
            begin
                if (send_wait > 0)
                begin
                    request_valid <= 1'b0;
                    send_wait     <= send_wait - 1;
                end
                else if (request_q.size() != 0 &&
                         (!request_q[0].drain_first ||
                          (outcome_q.size() == 0 && !request_valid)))
                begin
                    request       <= request_q[0].req;
                    request_valid <= 1'b1;
                    send_wait     <= pick_gap();
                    request_q.delete(0);
                end
                else
                    request_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted result against the oldest outcome owed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            recv_wait    = 0;
            hold_left    = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $error("result: none expected, got %p", result);
                    fail_count++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    if (result.region_address !== want.region_address)
                    begin
                        $error("region_address: expected %h, got %h",
                               want.region_address, result.region_address);
                        fail_count++;
                    end
                    if (result.region_pages !== want.region_pages)
                    begin
                        $error("region_pages: expected %h, got %h",
                               want.region_pages, result.region_pages);
                        fail_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $error("status: expected %h, got %h", want.status, result.status);
                        fail_count++;
                    end
                    if (result.legitimate !== want.legitimate)
                    begin
                        $error("legitimate: expected %h, got %h",
                               want.legitimate, result.legitimate);
                        fail_count++;
                    end
                end
                recv_wait = pick_gap();
            end
            // Start a long hold-off when asked; count it down here
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    // Watchdog: fail the run once the cycle count passes the limit, as when the block stops answering
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] p;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pool: base and size zero, so only zero-page regions fit
        offer(make_req(ACT_ALLOC, '0, '1), 1'b0);
        offer(make_req(ACT_ALLOC, 32'd1, '0), 1'b0);
        offer(make_req(ACT_CHECK, '1, '0), 1'b0);
        offer(make_req(ACT_UNUSED, '1, '1), 1'b0);
        offer(make_req(ACT_RELEASE, '0, PAGE_BYTES), 1'b0);
        offer(make_req(ACT_RELEASE, '1, PAGE_BYTES), 1'b0);
        wait_idle();

        // Pool at the top of the address space: starts wrap past zero
        write_reg(CFG_BASE, 32'hFFFF_F000);
        write_reg(CFG_POOL, 32'hFFFF_FFFF);
        offer(make_req(ACT_ALLOC, 32'hFFFF_FFFF, '0), 1'b0);
        offer(make_req(ACT_ALLOC, 32'hFFFF_F000, '0), 1'b0);
        offer(make_req(ACT_ALLOC, '0, '0), 1'b0);
        offer(make_req(ACT_ALLOC, 32'd1, '0), 1'b0);
        offer(make_req(ACT_CHECK, '0, 32'hFFFF_EFFF), 1'b0);
        offer(make_req(ACT_CHECK, '0, 32'hFFFF_F000), 1'b0);
        offer(make_req(ACT_CHECK, '0, 32'hFFFF_FFFF), 1'b0);
        offer(make_req(ACT_CHECK, '0, '0), 1'b0);
        offer(make_req(ACT_RELEASE, '0, 32'h1234_5678), 1'b0);
        offer(make_req(ACT_RELEASE, '0, 32'hFFFF_F000), 1'b0);
        offer(make_req(ACT_RELEASE, '0, '0), 1'b0);
        offer(make_req(ACT_RELEASE, '0, '0), 1'b0);
        offer(make_req(ACT_UNUSED, '0, '0), 1'b0);
        wait_idle();

        // Fill the table with regions of at most one page, then overfill it
        b = 32'h0040_0000;
        p = 32'h0020_0000;
        write_reg(CFG_BASE, b);
        write_reg(CFG_POOL, p);
        for (int n = 0; n < FILL_ALLOCS; n++)
            offer(make_req(ACT_ALLOC, ($urandom_range(0, 2) == 0) ? 32'd0 :
                           32'($urandom_range(1, PAGE_BYTES)), $urandom()), 1'b0);
        offer(make_req(ACT_ALLOC, 32'hFFFF_FFFF, $urandom()), 1'b0);
        offer(make_req(ACT_ALLOC, '0, $urandom()), 1'b0);
        offer(make_req(ACT_RELEASE, $urandom(), b + PAGE_BYTES), 1'b0);
        for (int n = 0; n < 12; n++)
        begin
            offer(make_req(ACT_RELEASE, $urandom(),
                           b + PAGE_BYTES * $urandom_range(1, 200)), 1'b0);
            if (n % 3 == 0)
                offer(make_req(ACT_ALLOC, 2 * PAGE_BYTES, $urandom()), 1'b0);
        end
        wait_idle();

        // Random phases, each on a different pool setting
        for (int ph = 0; ph < 6; ph++)
        begin
            calm = (ph == 0);
            case (ph)
                0:
                begin
                    write_reg(CFG_BASE, '0);
                    write_reg(CFG_POOL, 32'hFFFF_FFFF);
                end
                1:
                begin
                    write_reg(CFG_BASE, 32'hFFFF_F000);
                    write_reg(CFG_POOL, 32'h0001_0000);
                end
                2:
                begin
                    write_reg(CFG_BASE, $urandom());
                    write_reg(CFG_POOL, $urandom());
                end
                3:
                    write_reg(CFG_POOL, '0);
                4:
                begin
                    write_reg(CFG_BASE, 32'h8000_0000);
                    write_reg(CFG_POOL, 32'h0000_8000);
                end
                default:
                    write_reg(CFG_BASE, $urandom() & ~(PAGE_BYTES - 1));
            endcase
            // Stall the result side so the block backs up into its input
            if (ph == 1 || ph == 4)
                hold_asks++;
            for (int n = 0; n < 18; n++)
                offer(random_item(pool_base, pool_size, 48), n == 9);
            wait_idle();
        end

        if (outcome_q.size() != 0)
        begin
            $error("results missing: %0d", outcome_q.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
